@@ src/limit_orderbook_matcher_defines.svh @@
// Assertion macros shared by the order book matcher modules.
// Depends on nothing; the using module must have clk and rst_n in scope.
`ifndef LIMIT_ORDERBOOK_MATCHER_DEFINES_SVH
`define LIMIT_ORDERBOOK_MATCHER_DEFINES_SVH
`ifndef SYNTHESIS
`define LOM_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define LOM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LOM_ASSERT(lbl, cond, msg)
`define LOM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/lom_pkg.sv @@
// Types and codes of the order book matcher.
// Used by the controller, the datapath and the top level.
`default_nettype none
package lom_pkg;
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_EXEC   = 2'd2;

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_CANCEL  = 2'd1;
    localparam logic [1:0] KIND_FILL    = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;
    localparam logic [1:0] ST_ERR  = 2'd3;

    localparam logic [1:0] RD_IDX    = 2'd0;
    localparam logic [1:0] RD_IDX_M1 = 2'd1;
    localparam logic [1:0] RD_IDX_P1 = 2'd2;

    localparam logic [1:0] WR_NEW  = 2'd0;
    localparam logic [1:0] WR_COPY = 2'd1;
    localparam logic [1:0] WR_EXEC = 2'd2;

    localparam logic [62:0] AMOUNT_MAX = {63{1'b1}};

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] price;
        logic [62:0] amount;
        logic [63:0] account;
        logic [63:0] sequence_req;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] fill_account;
        logic [62:0] paid_amount;
        logic [62:0] taken_amount;
        logic        found;
        logic [1:0]  status;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [63:0] price;
        logic [62:0] amount;
        logic [63:0] owner;
        logic [63:0] sequence_no;
    } entry_t;

    typedef struct packed {
        logic       load_in;
        logic       clr_idx;
        logic       inc_idx;
        logic       dec_idx;
        logic       idx_to_count;
        logic       save_pos;
        logic       restore_idx;
        logic       rd_en;
        logic [1:0] rd_mode;
        logic       wr_en;
        logic [1:0] wr_mode;
        logic       inc_count;
        logic       dec_count;
        logic       mul_start;
        logic       sel_q;
        logic       div_start;
        logic       fill_upd;
        logic       emit;
        logic [1:0] emit_kind;
        logic [1:0] emit_status;
        logic       emit_found;
    } ctl_t;

    typedef struct packed {
        logic [1:0] op;
        logic       price_zero;
        logic       idx_eq_count;
        logic       idx_eq_pos;
        logic       idx_p1_eq_count;
        logic       book_full;
        logic       key_lt;
        logic       key_eq;
        logic       rem_zero;
        logic       price_ok;
        logic       mul_done;
        logic       div_done;
        logic       taken_full;
    } sts_t;
endpackage
`default_nettype wire

@@ src/lom_controller.sv @@
// Sequencing state machine of the order book matcher.
// Depends on lom_pkg and the assertion macro header.
`default_nettype none
`include "limit_orderbook_matcher_defines.svh"
module lom_controller
    import lom_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  sts_t      sts,
    output ctl_t      cmd
);
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DISP   = 5'd1;
    localparam logic [4:0] S_A_CHK  = 5'd2;
    localparam logic [4:0] S_A_CMP  = 5'd3;
    localparam logic [4:0] S_IN_CHK = 5'd4;
    localparam logic [4:0] S_IN_WR  = 5'd5;
    localparam logic [4:0] S_C_CHK  = 5'd6;
    localparam logic [4:0] S_C_CMP  = 5'd7;
    localparam logic [4:0] S_RM_CHK = 5'd8;
    localparam logic [4:0] S_RM_WR  = 5'd9;
    localparam logic [4:0] S_RM_END = 5'd10;
    localparam logic [4:0] S_E_RD   = 5'd11;
    localparam logic [4:0] S_E_CHK  = 5'd12;
    localparam logic [4:0] S_E_MUL  = 5'd13;
    localparam logic [4:0] S_E_SEL  = 5'd14;
    localparam logic [4:0] S_E_DIV0 = 5'd15;
    localparam logic [4:0] S_E_DIV  = 5'd16;
    localparam logic [4:0] S_E_FILL = 5'd17;
    localparam logic [4:0] S_E_SUM  = 5'd18;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_in = 1'b1;
                    cmd.clr_idx = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                priority if (sts.op == OP_ADD)
                begin
                    if (sts.price_zero)
                    begin
                        cmd.emit = 1'b1;
                        cmd.emit_kind = KIND_ACK;
                        cmd.emit_status = ST_ZERO;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_A_CHK;
                    end
                end
                else if (sts.op == OP_CANCEL)
                begin
                    state_next = S_C_CHK;
                end
                else if (sts.op == OP_EXEC)
                begin
                    state_next = S_E_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_A_CHK:
            begin
                if (sts.idx_eq_count)
                begin
                    if (sts.book_full)
                    begin
                        cmd.emit = 1'b1;
                        cmd.emit_kind = KIND_ACK;
                        cmd.emit_status = ST_FULL;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.save_pos = 1'b1;
                        cmd.idx_to_count = 1'b1;
                        state_next = S_IN_CHK;
                    end
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_mode = RD_IDX;
                    state_next = S_A_CMP;
                end
            end
            S_A_CMP:
            begin
                priority if (sts.key_lt)
                begin
                    cmd.inc_idx = 1'b1;
                    state_next = S_A_CHK;
                end
                else if (sts.key_eq)
                begin
                    cmd.wr_en = 1'b1;
                    cmd.wr_mode = WR_NEW;
                    cmd.emit = 1'b1;
                    cmd.emit_kind = KIND_ACK;
                    cmd.emit_status = ST_OK;
                    state_next = S_IDLE;
                end
                else if (sts.book_full)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_kind = KIND_ACK;
                    cmd.emit_status = ST_FULL;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.save_pos = 1'b1;
                    cmd.idx_to_count = 1'b1;
                    state_next = S_IN_CHK;
                end
            end
            S_IN_CHK:
            begin
                if (sts.idx_eq_pos)
                begin
                    cmd.wr_en = 1'b1;
                    cmd.wr_mode = WR_NEW;
                    cmd.inc_count = 1'b1;
                    cmd.emit = 1'b1;
                    cmd.emit_kind = KIND_ACK;
                    cmd.emit_status = ST_OK;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_mode = RD_IDX_M1;
                    state_next = S_IN_WR;
                end
            end
            S_IN_WR:
            begin
                cmd.wr_en = 1'b1;
                cmd.wr_mode = WR_COPY;
                cmd.dec_idx = 1'b1;
                state_next = S_IN_CHK;
            end
            S_C_CHK:
            begin
                if (sts.idx_eq_count)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_kind = KIND_CANCEL;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_mode = RD_IDX;
                    state_next = S_C_CMP;
                end
            end
            S_C_CMP:
            begin
                if (sts.key_eq)
                begin
                    cmd.save_pos = 1'b1;
                    state_next = S_RM_CHK;
                end
                else
                begin
                    cmd.inc_idx = 1'b1;
                    state_next = S_C_CHK;
                end
            end
            S_RM_CHK:
            begin
                if (sts.idx_p1_eq_count)
                begin
                    state_next = S_RM_END;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_mode = RD_IDX_P1;
                    state_next = S_RM_WR;
                end
            end
            S_RM_WR:
            begin
                cmd.wr_en = 1'b1;
                cmd.wr_mode = WR_COPY;
                cmd.inc_idx = 1'b1;
                state_next = S_RM_CHK;
            end
            S_RM_END:
            begin
                cmd.dec_count = 1'b1;
                cmd.restore_idx = 1'b1;
                if (sts.op == OP_EXEC)
                begin
                    state_next = S_E_RD;
                end
                else
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_kind = KIND_CANCEL;
                    cmd.emit_found = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_E_RD:
            begin
                if (sts.idx_eq_count || sts.rem_zero)
                begin
                    state_next = S_E_SUM;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_mode = RD_IDX;
                    state_next = S_E_CHK;
                end
            end
            S_E_CHK:
            begin
                if (sts.price_ok)
                begin
                    cmd.mul_start = 1'b1;
                    state_next = S_E_MUL;
                end
                else
                begin
                    state_next = S_E_SUM;
                end
            end
            S_E_MUL:
            begin
                if (sts.mul_done)
                begin
                    state_next = S_E_SEL;
                end
            end
            S_E_SEL:
            begin
                cmd.sel_q = 1'b1;
                state_next = S_E_DIV0;
            end
            S_E_DIV0:
            begin
                cmd.div_start = 1'b1;
                state_next = S_E_DIV;
            end
            S_E_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_E_FILL;
                end
            end
            S_E_FILL:
            begin
                cmd.fill_upd = 1'b1;
                cmd.emit = 1'b1;
                cmd.emit_kind = KIND_FILL;
                if (sts.taken_full)
                begin
                    cmd.save_pos = 1'b1;
                    state_next = S_RM_CHK;
                end
                else
                begin
                    cmd.wr_en = 1'b1;
                    cmd.wr_mode = WR_EXEC;
                    state_next = S_E_SUM;
                end
            end
            S_E_SUM:
            begin
                cmd.emit = 1'b1;
                cmd.emit_kind = KIND_SUMMARY;
                cmd.emit_status = ST_OK;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `LOM_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "accepted item did not raise busy")
    `LOM_ASSERT(a_one_action, $onehot0({cmd.mul_start, cmd.div_start, cmd.sel_q}), "overlapping unit commands")
    `LOM_ASSERT(a_idle_quiet, !busy |-> !cmd.emit && !cmd.wr_en, "idle controller issued work")
endmodule
`default_nettype wire

@@ src/lom_datapath.sv @@
// Datapath of the order book matcher: offer memory, index counters,
// split multiplier, bit-serial divider and result register. Depends on lom_pkg and the assertion macro header.
`default_nettype none
`include "limit_orderbook_matcher_defines.svh"
module lom_datapath
    import lom_pkg::*;
#(
    parameter int BOOK_DEPTH = 32,
    parameter int PRICE_FRACTION_BITS = 24
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  in_item_t  in_item,
    input  ctl_t      cmd,
    output sts_t      sts,
    output logic      res_valid,
    output out_item_t res
);
    localparam int IDX_W = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
    localparam int CNT_W = $clog2(BOOK_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BOOK_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);
    localparam logic [127:0] FRAC_MASK = (128'd1 << PRICE_FRACTION_BITS) - 128'd1;

    entry_t mem [BOOK_DEPTH];
    entry_t rd_reg;
    in_item_t in_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] pos_reg;
    logic [CNT_W-1:0] rd_idx;
    logic [62:0] rem_reg;
    logic [62:0] bought_reg;
    logic over_reg;
    logic [2:0] mul_cnt_reg;
    logic mul_done_reg;
    logic [63:0] prod_reg;
    logic [6:0] sh_reg;
    logic [127:0] acc_reg;
    logic [127:0] q_reg;
    logic [63:0] paid_reg;
    logic [7:0] div_cnt_reg;
    logic div_done_reg;
    logic [127:0] dvd_reg;
    logic [63:0] r_reg;
    logic [63:0] quo_reg;
    logic res_valid_reg;
    out_item_t res_reg;
    entry_t wr_data;
    logic [63:0] amt64;
    logic [63:0] taken_c;
    logic [63:0] bought_sum;
    logic [127:0] rem_sh;
    logic [127:0] q_sh;
    logic [63:0] paid_raw;
    logic [64:0] r_shift;
    logic div_sub;

    assign amt64 = {1'b0, rd_reg.amount};
    assign taken_c = (rd_reg.price == 64'd0) ? amt64 : ((quo_reg > amt64) ? amt64 : quo_reg);
    assign bought_sum = {1'b0, bought_reg} + taken_c;
    assign rem_sh = {65'd0, rem_reg} << PRICE_FRACTION_BITS;
    assign q_sh = q_reg >> PRICE_FRACTION_BITS;
    assign paid_raw = q_sh[63:0] + {63'd0, |(q_reg & FRAC_MASK)};
    assign r_shift = {r_reg, dvd_reg[127]};
    assign div_sub = r_shift[64] || (r_shift[63:0] >= rd_reg.price);

    always_comb
    begin
        unique case (cmd.rd_mode)
            RD_IDX_M1: rd_idx = idx_reg - ONE_C;
            RD_IDX_P1: rd_idx = idx_reg + ONE_C;
            default:   rd_idx = idx_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.wr_mode)
            WR_COPY: wr_data = rd_reg;
            WR_EXEC:
            begin
                wr_data = rd_reg;
                wr_data.amount = rd_reg.amount - taken_c[62:0];
            end
            default:
            begin
                wr_data.price = in_reg.price;
                wr_data.amount = in_reg.amount;
                wr_data.owner = in_reg.account;
                wr_data.sequence_no = in_reg.sequence_req;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[idx_reg[IDX_W-1:0]] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_reg <= mem[rd_idx[IDX_W-1:0]];
        end
        if (cmd.load_in)
        begin
            in_reg <= in_item;
        end
        if (cmd.sel_q)
        begin
            q_reg <= (acc_reg <= rem_sh) ? acc_reg : rem_sh;
        end
        if (cmd.div_start)
        begin
            paid_reg <= (paid_raw > {1'b0, rem_reg}) ? {1'b0, rem_reg} : paid_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg <= '0;
            pos_reg <= '0;
            rem_reg <= '0;
            bought_reg <= '0;
            over_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= cmd.emit;
            priority if (cmd.clr_idx)
                idx_reg <= '0;
            else if (cmd.idx_to_count)
                idx_reg <= count_reg;
            else if (cmd.restore_idx)
                idx_reg <= pos_reg;
            else if (cmd.inc_idx)
                idx_reg <= idx_reg + ONE_C;
            else if (cmd.dec_idx)
                idx_reg <= idx_reg - ONE_C;
            if (cmd.save_pos)
                pos_reg <= idx_reg;
            if (cmd.inc_count)
                count_reg <= count_reg + ONE_C;
            else if (cmd.dec_count)
                count_reg <= count_reg - ONE_C;
            if (cmd.load_in)
            begin
                rem_reg <= in_item.amount;
                bought_reg <= '0;
                over_reg <= 1'b0;
            end
            else if (cmd.fill_upd)
            begin
                rem_reg <= rem_reg - paid_reg[62:0];
                if (bought_sum > {1'b0, AMOUNT_MAX})
                begin
                    bought_reg <= AMOUNT_MAX;
                    over_reg <= 1'b1;
                end
                else
                begin
                    bought_reg <= bought_sum[62:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_cnt_reg <= '0;
            mul_done_reg <= 1'b0;
        end
        else if (cmd.mul_start)
        begin
            mul_cnt_reg <= 3'd1;
            mul_done_reg <= 1'b0;
        end
        else if (mul_cnt_reg == 3'd5)
        begin
            mul_cnt_reg <= '0;
            mul_done_reg <= 1'b1;
        end
        else if (mul_cnt_reg != 3'd0)
        begin
            mul_cnt_reg <= mul_cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            acc_reg <= '0;
        end
        else if (mul_cnt_reg >= 3'd2)
        begin
            acc_reg <= acc_reg + ({64'd0, prod_reg} << sh_reg);
        end
        unique case (mul_cnt_reg)
            3'd1:
            begin
                prod_reg <= rd_reg.price[31:0] * amt64[31:0];
                sh_reg <= 7'd0;
            end
            3'd2:
            begin
                prod_reg <= rd_reg.price[31:0] * amt64[63:32];
                sh_reg <= 7'd32;
            end
            3'd3:
            begin
                prod_reg <= rd_reg.price[63:32] * amt64[31:0];
                sh_reg <= 7'd32;
            end
            3'd4:
            begin
                prod_reg <= rd_reg.price[63:32] * amt64[63:32];
                sh_reg <= 7'd64;
            end
            default:
            begin
                prod_reg <= prod_reg;
                sh_reg <= sh_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
            div_done_reg <= 1'b0;
        end
        else if (cmd.div_start)
        begin
            div_cnt_reg <= 8'd128;
            div_done_reg <= 1'b0;
        end
        else if (div_cnt_reg != 8'd0)
        begin
            div_cnt_reg <= div_cnt_reg - 8'd1;
            if (div_cnt_reg == 8'd1)
                div_done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dvd_reg <= q_reg;
            r_reg <= '0;
            quo_reg <= '0;
        end
        else if (div_cnt_reg != 8'd0)
        begin
            dvd_reg <= {dvd_reg[126:0], 1'b0};
            if (div_sub)
            begin
                r_reg <= r_shift[63:0] - rd_reg.price;
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                r_reg <= r_shift[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_reg.kind <= cmd.emit_kind;
            res_reg.found <= cmd.emit_found;
            res_reg.last <= (cmd.emit_kind != KIND_FILL);
            unique case (cmd.emit_kind)
                KIND_FILL:
                begin
                    res_reg.status <= cmd.emit_status;
                    res_reg.fill_account <= rd_reg.owner;
                    res_reg.paid_amount <= paid_reg[62:0];
                    res_reg.taken_amount <= taken_c[62:0];
                end
                KIND_SUMMARY:
                begin
                    res_reg.status <= over_reg ? ST_ERR : cmd.emit_status;
                    res_reg.fill_account <= '0;
                    res_reg.paid_amount <= in_reg.amount - rem_reg;
                    res_reg.taken_amount <= bought_reg;
                end
                default:
                begin
                    res_reg.status <= cmd.emit_status;
                    res_reg.fill_account <= '0;
                    res_reg.paid_amount <= '0;
                    res_reg.taken_amount <= '0;
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res = res_reg;

    assign sts.op = in_reg.operation;
    assign sts.price_zero = (in_reg.price == 64'd0);
    assign sts.idx_eq_count = (idx_reg == count_reg);
    assign sts.idx_eq_pos = (idx_reg == pos_reg);
    assign sts.idx_p1_eq_count = ((idx_reg + ONE_C) == count_reg);
    assign sts.book_full = (count_reg >= DEPTH_C);
    assign sts.key_lt = ({rd_reg.price, rd_reg.owner, rd_reg.sequence_no}
                         < {in_reg.price, in_reg.account, in_reg.sequence_req});
    assign sts.key_eq = ({rd_reg.price, rd_reg.owner, rd_reg.sequence_no}
                         == {in_reg.price, in_reg.account, in_reg.sequence_req});
    assign sts.rem_zero = (rem_reg == 63'd0);
    assign sts.price_ok = (rd_reg.price <= in_reg.price);
    assign sts.mul_done = mul_done_reg;
    assign sts.div_done = div_done_reg;
    assign sts.taken_full = (taken_c == amt64);

    `LOM_ASSERT(a_count_bound, count_reg <= DEPTH_C, "entry count exceeds the book depth")
    `LOM_ASSERT(a_idx_bound, idx_reg <= count_reg, "index beyond the entry count")
    `LOM_ASSERT_NEXT(a_fill_count, cmd.inc_count, count_reg <= DEPTH_C && count_reg != '0, "insert left a bad count")
endmodule
`default_nettype wire

@@ src/limit_orderbook_matcher.sv @@
// Order book matcher top level: one side of a sorted limit order book.
// Add: scans the entries in order, shifts the later entries up to make room, then gives one result item.
// Cancel: scans the entries, then shifts the later entries down over the removed one.
// Execute: each fill runs the split multiplier and the one-bit-a-cycle 128-step divider, and a fully
// taken entry is removed by shifting the later entries down; results come as one-cycle strobes.
// Reset clears the entry count and the controller; stored offers are not cleared.
`default_nettype none
module limit_orderbook_matcher
    import lom_pkg::*;
#(
    parameter int BOOK_DEPTH = 32,
    parameter int PRICE_FRACTION_BITS = 24
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  in_item_t  in_item,
    output logic      res_valid,
    output out_item_t res
);
    ctl_t cmd;
    sts_t sts;

    lom_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    lom_datapath #(
        .BOOK_DEPTH          (BOOK_DEPTH),
        .PRICE_FRACTION_BITS (PRICE_FRACTION_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .sts       (sts),
        .res_valid (res_valid),
        .res       (res)
    );
endmodule
`default_nettype wire
